/* rtl/vtq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vtq_pkg
// Shared sizes, codes and controller/datapath interface types for the
// versioned timer queue.
// ----------------------------------------------------------------------------
package vtq_pkg;

   localparam int SLOTS  = 16;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int VER_W  = 16;
   localparam int TIME_W = 63;
   localparam int MODE_W = 2;
   localparam int STAT_W = 2;

   localparam logic [VER_W-1:0] VER_INIT = VER_W'(2);
   localparam logic [VER_W-1:0] VER_STEP = VER_W'(2);

   // request codes
   localparam logic [MODE_W-1:0] MODE_SCHEDULE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CANCEL   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK     = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_LATE  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_STALE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_SCHED,
      ST_CANCEL_RD,
      ST_CANCEL,
      ST_TICK_DECIDE,
      ST_TICK_VER
   } state_type;

   typedef enum logic [1:0] {
      VSEL_FREE,
      VSEL_BEST,
      VSEL_CANCEL
   } ver_sel_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_SCHED,
      EMIT_FULL,
      EMIT_CANCEL,
      EMIT_FIRE_MORE,
      EMIT_FIRE_LAST,
      EMIT_TICK_NONE
   } emit_type;

   typedef struct packed {
      logic              latch;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              ver_rd;
      ver_sel_type       ver_sel;
      logic              sched_commit;
      logic              cancel_commit;
      logic              fire_take;
      logic              pend_load;
      emit_type          emit;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic best_valid;
      logic pend_valid;
   } stat_type;

endpackage
`default_nettype wire

/* rtl/vtq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vtq_ctrl
// Sequencer: walks the slot table, drives datapath commands, tracks busy.
// ----------------------------------------------------------------------------
module vtq_ctrl
   import vtq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [MODE_W-1:0] req_mode,
   input  wire stat_type          stat,
   output logic                   busy,
   output cmd_type                cmd
);

   state_type         state_ff, state_in;
   logic              tick_ff, tick_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic              accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tick_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      tick_in  = tick_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               case (req_mode)
                  MODE_SCHEDULE: begin
                     state_in = ST_SCAN;
                     tick_in  = 1'b0;
                  end
                  MODE_TICK: begin
                     state_in = ST_SCAN;
                     tick_in  = 1'b1;
                  end
                  MODE_CANCEL: state_in = ST_CANCEL_RD;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + SLOT_W'(1);
            if (cnt_ff == SLOT_W'(SLOTS - 1)) begin
               cnt_in   = '0;
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END:    state_in = tick_ff ? ST_TICK_DECIDE : ST_SCHED;
         ST_SCHED:       state_in = ST_IDLE;
         ST_CANCEL_RD:   state_in = ST_CANCEL;
         ST_CANCEL:      state_in = ST_IDLE;
         ST_TICK_DECIDE: state_in = stat.best_valid ? ST_TICK_VER : ST_IDLE;
         ST_TICK_VER:    state_in = ST_SCAN;
         default:        state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd         = '0;
      cmd.ver_sel = VSEL_FREE;
      cmd.emit    = EMIT_NONE;
      cmd.latch   = accept;
      case (state_ff)
         ST_SCAN: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = cnt_ff;
         end
         ST_SCAN_END: begin
            cmd.ver_rd  = 1'b1;
            cmd.ver_sel = VSEL_FREE;
         end
         ST_SCHED: begin
            cmd.sched_commit = !stat.full;
            cmd.emit         = stat.full ? EMIT_FULL : EMIT_SCHED;
         end
         ST_CANCEL_RD: begin
            cmd.ver_rd  = 1'b1;
            cmd.ver_sel = VSEL_CANCEL;
         end
         ST_CANCEL: begin
            cmd.cancel_commit = 1'b1;
            cmd.emit          = EMIT_CANCEL;
         end
         ST_TICK_DECIDE: begin
            if (stat.best_valid) begin
               cmd.fire_take = 1'b1;
               cmd.ver_rd    = 1'b1;
               cmd.ver_sel   = VSEL_BEST;
               cmd.emit      = stat.pend_valid ? EMIT_FIRE_MORE : EMIT_NONE;
            end else begin
               cmd.emit      = stat.pend_valid ? EMIT_FIRE_LAST : EMIT_TICK_NONE;
            end
         end
         ST_TICK_VER: cmd.pend_load = 1'b1;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/vtq_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vtq_datapath
// Slot table storage, deadline scan compare, version update and result regs.
// ----------------------------------------------------------------------------
module vtq_datapath
   import vtq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   input  wire logic [TIME_W-1:0] req_time_us,
   input  wire logic [SLOT_W-1:0] req_cancel_slot,
   input  wire logic [VER_W-1:0]  req_cancel_version,
   output stat_type               stat,
   output logic                   rsp_valid,
   output logic [SLOT_W-1:0]      rsp_out_slot,
   output logic [VER_W-1:0]       rsp_out_version,
   output logic                   rsp_earlier,
   output logic [STAT_W-1:0]      rsp_status,
   output logic                   rsp_fired,
   output logic                   rsp_last
);

   // storage
   logic [TIME_W-1:0] dl_mem [SLOTS];
   logic [VER_W-1:0]  ver_mem [SLOTS];
   logic [SLOTS-1:0]  busy_ff, fired_ff, ver_wr_ff;

   // latched request
   logic [TIME_W-1:0] t_ff;
   logic [SLOT_W-1:0] cs_ff;
   logic [VER_W-1:0]  cv_ff;

   // scan pipeline
   logic [TIME_W-1:0] dl_rd_ff;
   logic              chk_valid_ff;
   logic [SLOT_W-1:0] chk_idx_ff;
   logic              best_valid_ff;
   logic [SLOT_W-1:0] best_idx_ff;
   logic [TIME_W-1:0] best_dl_ff;
   logic              earlier_ff;

   // version read
   logic [VER_W-1:0]  ver_rd_ff;
   logic              ver_wr_rd_ff;
   logic [SLOT_W-1:0] ver_addr;
   logic [VER_W-1:0]  ver_cur, ver_next;

   // pending fired timer
   logic              pend_valid_ff;
   logic [SLOT_W-1:0] pend_slot_ff;
   logic [VER_W-1:0]  pend_ver_ff;

   logic              rsp_valid_ff;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [VER_W-1:0]  rsp_ver_ff, rsp_ver_in;
   logic              rsp_earlier_ff, rsp_fired_ff, rsp_last_ff;
   logic              rsp_earlier_in, rsp_fired_in, rsp_last_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;

   logic [SLOT_W-1:0] free_idx;
   logic              full;
   logic              due, better, scan_clear;
   logic              cv_match;
   logic [STAT_W-1:0] cancel_stat;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      full     = 1'b1;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_idx = SLOT_W'(i);
            full     = 1'b0;
         end
      end
   end

   assign due        = chk_valid_ff && busy_ff[chk_idx_ff] && (dl_rd_ff <= t_ff);
   assign better     = !best_valid_ff || (dl_rd_ff < best_dl_ff);
   assign scan_clear = cmd.latch || cmd.pend_load;

   always_comb begin
      case (cmd.ver_sel)
         VSEL_FREE:   ver_addr = free_idx;
         VSEL_BEST:   ver_addr = best_idx_ff;
         VSEL_CANCEL: ver_addr = cs_ff;
         default:     ver_addr = free_idx;
      endcase
   end

   assign ver_cur  = ver_wr_rd_ff ? ver_rd_ff : VER_INIT;
   assign ver_next = ((ver_cur + VER_STEP) == '0) ? VER_INIT : (ver_cur + VER_STEP);
   assign cv_match = (ver_cur == cv_ff);

   always_comb begin
      cancel_stat = STAT_STALE;
      if (cv_match && busy_ff[cs_ff]) begin
         cancel_stat = STAT_OK;
      end else if (cv_match && fired_ff[cs_ff]) begin
         cancel_stat = STAT_LATE;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.sched_commit) begin
         dl_mem[free_idx]  <= t_ff;
         ver_mem[free_idx] <= ver_next;
      end
      dl_rd_ff <= dl_mem[cmd.rd_addr];
      if (cmd.ver_rd) begin
         ver_rd_ff <= ver_mem[ver_addr];
      end
   end

   // slot flags
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= '0;
         fired_ff  <= '0;
         ver_wr_ff <= '0;
      end else begin
         if (cmd.sched_commit) begin
            busy_ff[free_idx]   <= 1'b1;
            fired_ff[free_idx]  <= 1'b0;
            ver_wr_ff[free_idx] <= 1'b1;
         end
         if (cmd.cancel_commit && cancel_stat == STAT_OK) begin
            busy_ff[cs_ff] <= 1'b0;
         end
         if (cmd.fire_take) begin
            busy_ff[best_idx_ff]  <= 1'b0;
            fired_ff[best_idx_ff] <= 1'b1;
         end
      end
   end

   // request capture, read-side registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         t_ff  <= req_time_us;
         cs_ff <= req_cancel_slot;
         cv_ff <= req_cancel_version;
      end
      chk_idx_ff <= cmd.rd_addr;
      if (cmd.ver_rd) begin
         ver_wr_rd_ff <= ver_wr_ff[ver_addr];
      end
      if (cmd.fire_take) begin
         pend_slot_ff <= best_idx_ff;
      end
      if (cmd.pend_load) begin
         pend_ver_ff <= ver_cur;
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         earlier_ff    <= 1'b1;
         pend_valid_ff <= 1'b0;
      end else begin
         chk_valid_ff <= cmd.rd_en;
         if (scan_clear) begin
            best_valid_ff <= 1'b0;
            earlier_ff    <= 1'b1;
         end else if (due) begin
            earlier_ff <= 1'b0;
            if (better) begin
               best_valid_ff <= 1'b1;
            end
         end
         if (cmd.latch) begin
            pend_valid_ff <= 1'b0;
         end else if (cmd.pend_load) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (due && better) begin
         best_idx_ff <= chk_idx_ff;
         best_dl_ff  <= dl_rd_ff;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.emit != EMIT_NONE);
      end
   end

   always_comb begin
      rsp_slot_in    = '0;
      rsp_ver_in     = '0;
      rsp_earlier_in = 1'b0;
      rsp_status_in  = STAT_OK;
      rsp_fired_in   = 1'b0;
      rsp_last_in    = 1'b1;
      case (cmd.emit)
         EMIT_SCHED: begin
            rsp_slot_in    = free_idx;
            rsp_ver_in     = ver_next;
            rsp_earlier_in = earlier_ff;
         end
         EMIT_FULL: rsp_status_in = STAT_FULL;
         EMIT_CANCEL: begin
            rsp_slot_in   = cs_ff;
            rsp_ver_in    = cv_ff;
            rsp_status_in = cancel_stat;
         end
         EMIT_FIRE_MORE, EMIT_FIRE_LAST: begin
            rsp_slot_in  = pend_slot_ff;
            rsp_ver_in   = pend_ver_ff;
            rsp_fired_in = 1'b1;
            rsp_last_in  = (cmd.emit == EMIT_FIRE_LAST);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_slot_ff    <= rsp_slot_in;
      rsp_ver_ff     <= rsp_ver_in;
      rsp_earlier_ff <= rsp_earlier_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_fired_ff   <= rsp_fired_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign stat.full       = full;
   assign stat.best_valid = best_valid_ff;
   assign stat.pend_valid = pend_valid_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_slot    = rsp_slot_ff;
   assign rsp_out_version = rsp_ver_ff;
   assign rsp_earlier     = rsp_earlier_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_fired       = rsp_fired_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire

/* rtl/versioned_timer_queue_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// versioned_timer_queue_core
// Table of timer slots with versioned handles: schedule, cancel and tick
// (fire all due timers, earliest deadline first, ties to the lowest slot).
//
//   channel   | handshake          | payload
//   ----------+--------------------+-------------------------------------------
//   request   | start, busy        | req_mode, req_time_us, req_cancel_slot,
//             |                    | req_cancel_version
//   result    | rsp_valid (strobe) | rsp_out_slot, rsp_out_version, rsp_earlier,
//             |                    | rsp_status, rsp_fired, rsp_last
//
// A request is taken on a clock edge with start high and busy low; one
// request is handled at a time. Each scan reads the deadline memory one slot
// per cycle over the whole table.
//   schedule : one scan, then a version read and update, then the result
//   cancel   : a version read, then the result
//   tick     : one scan per fired timer plus one final empty scan;
//              each fired timer is reported after the following scan
// Results appear on a one-cycle strobe and cannot be stalled. Reset is
// synchronous: all slots free, not fired, versions back to their initial value.
// ----------------------------------------------------------------------------
module versioned_timer_queue_core
   import vtq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // request
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [MODE_W-1:0] req_mode,
   input  wire logic [TIME_W-1:0] req_time_us,
   input  wire logic [SLOT_W-1:0] req_cancel_slot,
   input  wire logic [VER_W-1:0]  req_cancel_version,
   // result
   output logic                   rsp_valid,
   output logic [SLOT_W-1:0]      rsp_out_slot,
   output logic [VER_W-1:0]       rsp_out_version,
   output logic                   rsp_earlier,
   output logic [STAT_W-1:0]      rsp_status,
   output logic                   rsp_fired,
   output logic                   rsp_last
);

   // command and status between the sequencer and the slot datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: scan counter and per-request flow
   vtq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   // slot table, compare logic and result registers
   vtq_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_time_us        (req_time_us),
      .req_cancel_slot    (req_cancel_slot),
      .req_cancel_version (req_cancel_version),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_out_slot       (rsp_out_slot),
      .rsp_out_version    (rsp_out_version),
      .rsp_earlier        (rsp_earlier),
      .rsp_status         (rsp_status),
      .rsp_fired          (rsp_fired),
      .rsp_last           (rsp_last)
   );

endmodule
`default_nettype wire
